FILE: hw/rtl/lgw_pkg.sv
// ----------------------------------------------------------------------------
// lgw_pkg: shared types and constants of the life generation block
// Cell codes, result record, register map and the B3/S23 update rule.
// ----------------------------------------------------------------------------
package lgw_pkg;

    // Cell codes as they appear on the cell and result channels.
    typedef logic [1:0] cell_t;

    localparam cell_t CELL_DEAD    = 2'd0;
    localparam cell_t CELL_ALIVE   = 2'd1;
    localparam cell_t CELL_BLOCKED = 2'd2;

    // Default grid limits, handed to the top level parameters.
    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    // Size registers as seen on the configuration port.
    localparam int         SIZE_W     = 7;
    localparam logic [6:0] SIZE_RESET = 7'd64;

    // Configuration port geometry and register map.
    localparam int   REG_ADDR_W      = 3;
    localparam int   REG_DATA_W      = 32;
    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    // Output queue depth; a power of two so the pointers wrap naturally.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_LVL_W = $clog2(FIFO_DEPTH + 1);

    // One result transaction.
    typedef struct packed {
        cell_t next_cell;
        logic  last_of_frame;
    } result_t;

    // Write request into the output queue.
    typedef struct packed {
        logic    push;
        result_t data;
    } fifo_write_t;

    // A cell counts as a live neighbor only when its code is alive.
    function automatic logic is_alive(input cell_t code);
        return (code == CELL_ALIVE);
    endfunction

    // B3/S23 with blocked cells kept and unused codes treated as dead.
    function automatic cell_t next_gen(input cell_t centre, input logic [3:0] cnt);
        cell_t res;
        res = CELL_DEAD;
        if (centre == CELL_BLOCKED) begin
            res = CELL_BLOCKED;
        end else if (centre == CELL_ALIVE && (cnt == 4'd2 || cnt == 4'd3)) begin
            res = CELL_ALIVE;
        end else if (centre == CELL_DEAD && cnt == 4'd3) begin
            res = CELL_ALIVE;
        end
        return res;
    endfunction

endpackage

FILE: hw/rtl/lgw_line_cell.sv
// ----------------------------------------------------------------------------
// lgw_line_cell: one storage cell of a line delay chain
// Takes the neighbor's value on each shift, or the fresh value at the head.
// ----------------------------------------------------------------------------
module lgw_line_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          shift_en,
    input  logic          head,
    input  lgw_pkg::cell_t inject,
    input  lgw_pkg::cell_t prev,
    output lgw_pkg::cell_t q
);
    import lgw_pkg::*;

    cell_t data_reg;
    cell_t data_next;

    // The head cell loads the new value, every other cell copies its neighbor.
    always_comb
    begin
        data_next = data_reg;
        if (shift_en)
        begin
            data_next = head ? inject : prev;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= CELL_DEAD;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign q = data_reg;

endmodule

FILE: hw/rtl/lgw_line_chain.sv
// ----------------------------------------------------------------------------
// lgw_line_chain: line delay built from a row of cells
// Delays the cell stream by exactly width transactions. The value enters at
// cell MAX_WIDTH - width and leaves at the last cell.
// ----------------------------------------------------------------------------
module lgw_line_chain #(
    parameter int MAX_WIDTH = lgw_pkg::DEF_MAX_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           shift_en,
    input  logic [$clog2(MAX_WIDTH+1)-1:0] width,
    input  lgw_pkg::cell_t                 din,
    output lgw_pkg::cell_t                 dout
);
    import lgw_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);

    cell_t tap [MAX_WIDTH];

    // Each cell knows its distance to the end and compares it to the width.
    for (genvar k = 0; k < MAX_WIDTH; k++)
    begin : g_cell
        localparam logic [WW-1:0] DIST = WW'(MAX_WIDTH - k);
        logic  head;
        cell_t prev;

        assign head = (width == DIST);

        if (k == 0)
        begin : g_first
            assign prev = din;
        end
        else
        begin : g_rest
            assign prev = tap[k-1];
        end

        lgw_line_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (shift_en),
            .head     (head),
            .inject   (din),
            .prev     (prev),
            .q        (tap[k])
        );
    end

    assign dout = tap[MAX_WIDTH-1];

endmodule

FILE: hw/rtl/lgw_out_fifo.sv
// ----------------------------------------------------------------------------
// lgw_out_fifo: result queue in front of the result channel
// Holds finished results so the cell side keeps flowing while the result
// side stalls. One write and one read per cycle; the read waits while out_stall is high.
// ----------------------------------------------------------------------------
module lgw_out_fifo (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lgw_pkg::fifo_write_t                wr,
    output logic                                out_valid,
    input  logic                                out_stall,
    output lgw_pkg::result_t                    out_data,
    output logic [lgw_pkg::FIFO_LVL_W-1:0]      level
);
    import lgw_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);

    result_t               mem_reg [FIFO_DEPTH];
    logic [PW-1:0]         wr_ptr_reg;
    logic [PW-1:0]         wr_ptr_next;
    logic [PW-1:0]         rd_ptr_reg;
    logic [PW-1:0]         rd_ptr_next;
    logic [FIFO_LVL_W-1:0] level_reg;
    logic [FIFO_LVL_W-1:0] level_next;
    logic                  pop;

    assign out_valid = (level_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign level     = level_reg;
    assign pop       = out_valid && !out_stall;

    // Pointer and fill level update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (wr.push)
        begin
            wr_ptr_next = wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + PW'(1);
        end
        if (wr.push && !pop)
        begin
            level_next = level_reg + FIFO_LVL_W'(1);
        end
        else if (!wr.push && pop)
        begin
            level_next = level_reg - FIFO_LVL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Queue storage carries payload only.
    always_ff @(posedge clk)
    begin
        if (wr.push)
        begin
            mem_reg[wr_ptr_reg] <= wr.data;
        end
    end

endmodule

FILE: hw/rtl/life_generation_with_walls.sv
// ----------------------------------------------------------------------------
// life_generation_with_walls: one B3/S23 generation on a walled, bounded grid
// Cells stream in raster order followed by one padding row; next-generation
// cells stream out in raster order with the final cell flagged.
// ----------------------------------------------------------------------------
// Throughput: one cell transaction per cycle while cell_stall is low, set by
//   the two line chains and the window, which all shift once per transaction.
// Results: a result is pushed into the output queue by the cell transaction
//   completing its neighborhood; a second result of a row end is deferred.
// Reset: counters clear, both size registers read 64, line cells and window
//   hold dead cells; no clearing pass, cells are taken from the first cycle.
// ----------------------------------------------------------------------------
module life_generation_with_walls #(
    parameter int MAX_WIDTH  = lgw_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lgw_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Cell channel.
    input  logic                             cell_valid,
    output logic                             cell_stall,
    input  lgw_pkg::cell_t                   cell_code,
    // Result channel.
    output logic                             result_valid,
    input  logic                             result_stall,
    output lgw_pkg::cell_t                   next_cell,
    output logic                             last_of_frame,
    // Configuration port.
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lgw_pkg::REG_ADDR_W-1:0]   paddr,
    input  logic [lgw_pkg::REG_DATA_W-1:0]   pwdata,
    output logic [lgw_pkg::REG_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import lgw_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    // Configuration and position registers.
    logic [SIZE_W-1:0] grid_width_reg;
    logic [SIZE_W-1:0] grid_width_next;
    logic [SIZE_W-1:0] grid_height_reg;
    logic [SIZE_W-1:0] grid_height_next;
    logic [CW-1:0]     col_reg;
    logic [CW-1:0]     col_next;
    logic [HW-1:0]     row_reg;
    logic [HW-1:0]     row_next;

    // Window columns zero and one; column two is the new input column.
    cell_t win_reg  [3][2];
    cell_t win_next [3][2];
    cell_t wn       [3][3];

    // Second result of a row end, queued in the cycle after the first.
    logic    defer_valid_reg;
    logic    defer_valid_next;
    result_t defer_data_reg;
    result_t defer_data_next;

    logic                  cfg_write;
    logic                  cell_accept;
    logic [WW-1:0]         w_eff;
    logic [HW-1:0]         h_eff;
    logic [CW-1:0]         c_cur;
    logic [HW-1:0]         r_cur;
    logic                  c_is_last;
    logic                  r_is_last;
    cell_t                 a_tap;
    cell_t                 b_tap;
    cell_t                 a_eff;
    cell_t                 b_eff;
    cell_t                 n_eff;
    logic [3:0]            cnt_mid;
    logic [3:0]            cnt_last;
    logic                  emit_mid;
    logic                  emit_last;
    result_t               mid_res;
    result_t               last_res;
    fifo_write_t           fifo_wr;
    result_t               fifo_out;
    logic [FIFO_LVL_W-1:0] fifo_level;
    logic [FIFO_LVL_W-1:0] occupancy;

    assign pready      = 1'b1;
    assign cfg_write   = psel && penable && pwrite && pready;
    assign cell_accept = cell_valid && !cell_stall;

    // Register read-back.
    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            REG_GRID_WIDTH:  prdata = REG_DATA_W'(grid_width_reg);
            REG_GRID_HEIGHT: prdata = REG_DATA_W'(grid_height_reg);
            default:         prdata = '0;
        endcase
    end

    // Sizes in use: zero acts as one, large values saturate at the maximum.
    always_comb
    begin
        if (grid_width_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (32'(grid_width_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(grid_width_reg);
        end

        if (grid_height_reg == '0)
        begin
            h_eff = HW'(1);
        end
        else if (32'(grid_height_reg) > 32'(MAX_HEIGHT))
        begin
            h_eff = HW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = HW'(grid_height_reg);
        end
    end

    // Current raster position and the masked column entering the window.
    always_comb
    begin
        c_cur = (WW'(col_reg) >= w_eff) ? '0 : col_reg;
        r_cur = (row_reg > h_eff) ? '0 : row_reg;
        c_is_last = (WW'(c_cur) == (w_eff - WW'(1)));
        r_is_last = (r_cur == h_eff);
        a_eff = (r_cur < HW'(2)) ? CELL_DEAD : a_tap;
        b_eff = (r_cur == '0) ? CELL_DEAD : b_tap;
        n_eff = (r_cur >= h_eff) ? CELL_DEAD : cell_code;
    end

    // Window after this transaction's shift; a row start clears old columns.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            wn[i][0] = (c_cur == '0) ? CELL_DEAD : win_reg[i][0];
            wn[i][1] = (c_cur == '0) ? CELL_DEAD : win_reg[i][1];
        end
        wn[0][2] = a_eff;
        wn[1][2] = b_eff;
        wn[2][2] = n_eff;
        for (int i = 0; i < 3; i++)
        begin
            win_next[i][0] = win_reg[i][0];
            win_next[i][1] = win_reg[i][1];
            if (cell_accept)
            begin
                win_next[i][0] = wn[i][1];
                win_next[i][1] = wn[i][2];
            end
        end
    end

    // Live neighbor counts for the middle cell and for the row's last cell.
    always_comb
    begin
        cnt_mid  = '0;
        cnt_last = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (!(i == 1 && j == 1))
                begin
                    cnt_mid = cnt_mid + {3'b000, is_alive(wn[i][j])};
                end
                if (j >= 1 && !(i == 1 && j == 2))
                begin
                    cnt_last = cnt_last + {3'b000, is_alive(wn[i][j])};
                end
            end
        end
    end

    // Results caused by this transaction.
    always_comb
    begin
        emit_mid  = cell_accept && (r_cur != '0) && (c_cur != '0);
        emit_last = cell_accept && (r_cur != '0) && c_is_last;
        mid_res.next_cell      = next_gen(wn[1][1], cnt_mid);
        mid_res.last_of_frame  = 1'b0;
        last_res.next_cell     = next_gen(wn[1][2], cnt_last);
        last_res.last_of_frame = r_is_last;
    end

    // Queue write: deferred row end first; a row start emits only at width one.
    always_comb
    begin
        fifo_wr.push = defer_valid_reg || emit_mid || emit_last;
        if (defer_valid_reg)
        begin
            fifo_wr.data = defer_data_reg;
        end
        else if (emit_mid)
        begin
            fifo_wr.data = mid_res;
        end
        else
        begin
            fifo_wr.data = last_res;
        end
        defer_valid_next = emit_mid && emit_last;
        defer_data_next  = last_res;
    end

    // Keep room for the results of one more transaction.
    assign occupancy  = fifo_level + FIFO_LVL_W'(defer_valid_reg);
    assign cell_stall = (occupancy > FIFO_LVL_W'(FIFO_DEPTH - 2));

    // Register writes, position counters and frame wrap.
    always_comb
    begin
        grid_width_next  = grid_width_reg;
        grid_height_next = grid_height_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        if (cfg_write)
        begin
            unique case (paddr[2])
                REG_GRID_WIDTH:  grid_width_next  = pwdata[SIZE_W-1:0];
                REG_GRID_HEIGHT: grid_height_next = pwdata[SIZE_W-1:0];
                default:         grid_width_next  = grid_width_reg;
            endcase
            col_next = '0;
            row_next = '0;
        end
        else if (cell_accept)
        begin
            if (c_is_last)
            begin
                col_next = '0;
                row_next = r_is_last ? '0 : (r_cur + HW'(1));
            end
            else
            begin
                col_next = c_cur + CW'(1);
                row_next = r_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= SIZE_RESET;
            grid_height_reg <= SIZE_RESET;
            col_reg         <= '0;
            row_reg         <= '0;
            defer_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= CELL_DEAD;
                win_reg[i][1] <= CELL_DEAD;
            end
        end
        else
        begin
            grid_width_reg  <= grid_width_next;
            grid_height_reg <= grid_height_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
            defer_valid_reg <= defer_valid_next;
            win_reg         <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        defer_data_reg <= defer_data_next;
    end

    // Line one delays the incoming row, line zero delays line one.
    lgw_line_chain #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (cell_accept),
        .width    (w_eff),
        .din      (n_eff),
        .dout     (b_tap)
    );

    lgw_line_chain #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line0 (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (cell_accept),
        .width    (w_eff),
        .din      (b_eff),
        .dout     (a_tap)
    );

    // Result queue drives the result channel.
    lgw_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (fifo_wr),
        .out_valid (result_valid),
        .out_stall (result_stall),
        .out_data  (fifo_out),
        .level     (fifo_level)
    );

    assign next_cell     = fifo_out.next_cell;
    assign last_of_frame = fifo_out.last_of_frame;

    // A deferred row end never collides with a result of the next transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        defer_valid_reg |-> !(emit_mid || emit_last))
        else $error("deferred result collides with a new result");

    // Two results from one transaction always leave the second one deferred.
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit_mid && emit_last) |=> defer_valid_reg)
        else $error("second result of a row end was lost");

    // A deferred result is queued and its flag clears in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        defer_valid_reg |=> !defer_valid_reg)
        else $error("deferred result held for more than one cycle");

endmodule
